// ----- design/psd_pkg.sv -----
package psd_pkg;

  // Event kinds carried by each result transaction.
  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_RELEASE = 2'd1,
    EV_CLEAR   = 2'd2
  } event_kind_e;

  // Prefix and sequence bytes of scan code set 2.
  localparam logic [7:0] CODE_PAUSE_LEAD = 8'hE1;
  localparam logic [7:0] CODE_EXTENDED   = 8'hE0;
  localparam logic [7:0] CODE_BREAK      = 8'hF0;
  localparam logic [7:0] CODE_PAUSE_A    = 8'h14;
  localparam logic [7:0] CODE_PAUSE_B    = 8'h77;
  localparam logic [7:0] CODE_PRTSC_A    = 8'h12;
  localparam logic [7:0] CODE_PRTSC_B    = 8'h7C;

  localparam logic [2:0] PAUSE_LAST_STEP = 3'd7;

  localparam logic [6:0] KEY_NONE         = 7'd0;
  localparam logic [6:0] KEY_PRINT_SCREEN = 7'd105;
  localparam logic [6:0] KEY_PAUSE        = 7'd106;

  // Depth of the result queue; two results may enter per cycle.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [2:0] pause_step;
    logic       ps_step;
    logic       ps_breaking;
    logic       break_pending;
    logic       ext_pending;
  } state_t;

  typedef struct packed {
    event_kind_e kind;
    logic [6:0]  key;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] key;
  } key_lookup_t;

  // Byte expected at each step of the pause sequence.
  function automatic logic [7:0] pause_expect(input logic [2:0] step);
    logic [7:0] code;
    case (step)
      3'd1:    code = CODE_PAUSE_A;
      3'd2:    code = CODE_PAUSE_B;
      3'd3:    code = CODE_PAUSE_LEAD;
      3'd4:    code = CODE_BREAK;
      3'd5:    code = CODE_PAUSE_A;
      3'd6:    code = CODE_BREAK;
      3'd7:    code = CODE_PAUSE_B;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

  // Standard keys, numbered in ascending scan code order.
  function automatic key_lookup_t std_lookup(input logic [7:0] code);
    key_lookup_t r;
    r.hit = 1'b1;
    case (code)
      8'h01: r.key = 7'd0;   8'h03: r.key = 7'd1;   8'h04: r.key = 7'd2;
      8'h05: r.key = 7'd3;   8'h06: r.key = 7'd4;   8'h07: r.key = 7'd5;
      8'h09: r.key = 7'd6;   8'h0A: r.key = 7'd7;   8'h0B: r.key = 7'd8;
      8'h0C: r.key = 7'd9;   8'h0D: r.key = 7'd10;  8'h0E: r.key = 7'd11;
      8'h11: r.key = 7'd12;  8'h12: r.key = 7'd13;  8'h14: r.key = 7'd14;
      8'h15: r.key = 7'd15;  8'h16: r.key = 7'd16;  8'h1A: r.key = 7'd17;
      8'h1B: r.key = 7'd18;  8'h1C: r.key = 7'd19;  8'h1D: r.key = 7'd20;
      8'h1E: r.key = 7'd21;  8'h21: r.key = 7'd22;  8'h22: r.key = 7'd23;
      8'h23: r.key = 7'd24;  8'h24: r.key = 7'd25;  8'h25: r.key = 7'd26;
      8'h26: r.key = 7'd27;  8'h29: r.key = 7'd28;  8'h2A: r.key = 7'd29;
      8'h2B: r.key = 7'd30;  8'h2C: r.key = 7'd31;  8'h2D: r.key = 7'd32;
      8'h2E: r.key = 7'd33;  8'h31: r.key = 7'd34;  8'h32: r.key = 7'd35;
      8'h33: r.key = 7'd36;  8'h34: r.key = 7'd37;  8'h35: r.key = 7'd38;
      8'h36: r.key = 7'd39;  8'h3A: r.key = 7'd40;  8'h3B: r.key = 7'd41;
      8'h3C: r.key = 7'd42;  8'h3D: r.key = 7'd43;  8'h3E: r.key = 7'd44;
      8'h41: r.key = 7'd45;  8'h42: r.key = 7'd46;  8'h43: r.key = 7'd47;
      8'h44: r.key = 7'd48;  8'h45: r.key = 7'd49;  8'h46: r.key = 7'd50;
      8'h49: r.key = 7'd51;  8'h4A: r.key = 7'd52;  8'h4B: r.key = 7'd53;
      8'h4C: r.key = 7'd54;  8'h4D: r.key = 7'd55;  8'h4E: r.key = 7'd56;
      8'h52: r.key = 7'd57;  8'h54: r.key = 7'd58;  8'h55: r.key = 7'd59;
      8'h58: r.key = 7'd60;  8'h59: r.key = 7'd61;  8'h5A: r.key = 7'd62;
      8'h5B: r.key = 7'd63;  8'h5D: r.key = 7'd64;  8'h66: r.key = 7'd65;
      8'h69: r.key = 7'd66;  8'h6B: r.key = 7'd67;  8'h6C: r.key = 7'd68;
      8'h70: r.key = 7'd69;  8'h71: r.key = 7'd70;  8'h72: r.key = 7'd71;
      8'h73: r.key = 7'd72;  8'h74: r.key = 7'd73;  8'h75: r.key = 7'd74;
      8'h76: r.key = 7'd75;  8'h77: r.key = 7'd76;  8'h78: r.key = 7'd77;
      8'h79: r.key = 7'd78;  8'h7A: r.key = 7'd79;  8'h7B: r.key = 7'd80;
      8'h7C: r.key = 7'd81;  8'h7D: r.key = 7'd82;  8'h7E: r.key = 7'd83;
      8'h83: r.key = 7'd84;
      default: begin
        r.hit = 1'b0;
        r.key = KEY_NONE;
      end
    endcase
    return r;
  endfunction

  // Extended keys (after E0), numbered from 85 in ascending scan code order.
  function automatic key_lookup_t ext_lookup(input logic [7:0] code);
    key_lookup_t r;
    r.hit = 1'b1;
    case (code)
      8'h11: r.key = 7'd85;  8'h14: r.key = 7'd86;  8'h1F: r.key = 7'd87;
      8'h27: r.key = 7'd88;  8'h2F: r.key = 7'd89;  8'h4A: r.key = 7'd90;
      8'h5A: r.key = 7'd91;  8'h69: r.key = 7'd92;  8'h6B: r.key = 7'd93;
      8'h6C: r.key = 7'd94;  8'h70: r.key = 7'd95;  8'h71: r.key = 7'd96;
      8'h72: r.key = 7'd97;  8'h74: r.key = 7'd98;  8'h75: r.key = 7'd99;
      8'h7A: r.key = 7'd100; 8'h7D: r.key = 7'd101;
      default: begin
        r.hit = 1'b0;
        r.key = KEY_NONE;
      end
    endcase
    return r;
  endfunction

endpackage

// ----- design/psd_decode.sv -----
module psd_decode import psd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] scan_byte_i,
  output push_t      push_o
);

  state_t      state_q, state_d;
  key_lookup_t std_hit, ext_hit;
  logic        do_clear, do_key, do_pause;
  logic        first_half;
  logic [6:0]  key_num;
  logic        key_brk;

  always_comb begin
    state_d    = state_q;
    do_clear   = 1'b0;
    do_key     = 1'b0;
    do_pause   = 1'b0;
    first_half = 1'b0;
    key_num    = KEY_NONE;
    key_brk    = state_q.break_pending;
    std_hit    = std_lookup(scan_byte_i);
    ext_hit    = ext_lookup(scan_byte_i);

    if (state_q.pause_step != 3'd0) begin
      if (scan_byte_i != pause_expect(state_q.pause_step)) begin
        do_clear = 1'b1;
      end else if (state_q.pause_step == PAUSE_LAST_STEP) begin
        do_pause = 1'b1;
      end else begin
        state_d.pause_step = 3'(state_q.pause_step + 3'd1);
      end
    end else if (scan_byte_i == CODE_PAUSE_LEAD) begin
      state_d.pause_step = 3'd1;
    end else if (scan_byte_i == CODE_EXTENDED) begin
      if (state_q.break_pending || state_q.ext_pending) begin
        do_clear = 1'b1;
      end else begin
        state_d.ext_pending = 1'b1;
      end
    end else if (scan_byte_i == CODE_BREAK) begin
      if (state_q.break_pending) begin
        do_clear = 1'b1;
      end else begin
        state_d.break_pending = 1'b1;
      end
    end else if (state_q.ext_pending) begin
      if (scan_byte_i inside {CODE_PRTSC_A, CODE_PRTSC_B}) begin
        // The first half of print screen is E0 12 on make and E0 F0 7C on break.
        first_half = (scan_byte_i == CODE_PRTSC_A) ? !state_q.break_pending
                                                   : state_q.break_pending;
        if (first_half == state_q.ps_step) begin
          do_clear = 1'b1;
        end else if (first_half) begin
          state_d.ps_breaking   = state_q.break_pending;
          state_d.ps_step       = 1'b1;
          state_d.ext_pending   = 1'b0;
          state_d.break_pending = 1'b0;
        end else if (state_q.ps_breaking != state_q.break_pending) begin
          do_clear = 1'b1;
        end else begin
          do_key  = 1'b1;
          key_num = KEY_PRINT_SCREEN;
        end
      end else if (state_q.ps_step || !ext_hit.hit) begin
        do_clear = 1'b1;
      end else begin
        do_key  = 1'b1;
        key_num = ext_hit.key;
      end
    end else if (!std_hit.hit) begin
      do_clear = 1'b1;
    end else begin
      do_key  = 1'b1;
      key_num = std_hit.key;
    end

    // Every byte that yields a result also ends all pending sequences.
    if (do_clear || do_key || do_pause) begin
      state_d = '0;
    end
  end

  always_comb begin
    push_o.second = '{kind: EV_RELEASE, key: KEY_PAUSE, last: 1'b1};
    if (do_pause) begin
      push_o.first = '{kind: EV_PRESS, key: KEY_PAUSE, last: 1'b0};
    end else if (do_key) begin
      push_o.first = '{kind: key_brk ? EV_RELEASE : EV_PRESS, key: key_num, last: 1'b1};
    end else begin
      push_o.first = '{kind: EV_CLEAR, key: KEY_NONE, last: 1'b1};
    end
    if (!fire_i) begin
      push_o.count = 2'd0;
    end else if (do_pause) begin
      push_o.count = 2'd2;
    end else if (do_key || do_clear) begin
      push_o.count = 2'd1;
    end else begin
      push_o.count = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (fire_i) begin
      state_q <= state_d;
    end
  end

`ifndef ASSERT_OFF
  a_result_clears_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.count != 2'd0 |=> state_q == '0)
    else $error("prefix state survived a byte that produced a result");

  a_pair_is_pause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.count == 2'd2 |-> push_o.first.key == KEY_PAUSE &&
      push_o.first.kind == EV_PRESS && !push_o.first.last && push_o.second.last)
    else $error("two results from a byte that did not complete pause");

  a_pause_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && state_q.pause_step != 3'd0 && push_o.count == 2'd0 |=>
      state_q.pause_step == 3'($past(state_q.pause_step) + 3'd1))
    else $error("pause sequence did not advance on a matching byte");
`endif

endmodule

// ----- design/psd_out_queue.sv -----
module psd_out_queue import psd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  push_t      push_i,
  output logic       room_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output result_t    head_o
);

  result_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CNT_W-1:0] count_q;
  logic                   pop;

  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign head_o      = mem_q[rd_ptr_q];
  // A byte may add two results, so it is only taken with two free slots.
  assign room_o      = (count_q <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[QUEUE_PTR_W'(wr_ptr_q + 1'b1)] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= QUEUE_PTR_W'(wr_ptr_q + QUEUE_PTR_W'(push_i.count));
      if (pop) begin
        rd_ptr_q <= QUEUE_PTR_W'(rd_ptr_q + 1'b1);
      end
      count_q <= QUEUE_CNT_W'(count_q + QUEUE_CNT_W'(push_i.count)
                              - QUEUE_CNT_W'(pop));
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("result queue overflowed");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.count != 2'd0 |-> room_o)
    else $error("results pushed without two free slots");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && push_i.count == 2'd0 |=> count_q == QUEUE_CNT_W'($past(count_q) - 1'b1))
    else $error("queue level did not drop after a pop");
`endif

endmodule

// ----- design/ps2_set2_scancode_decoder_core.sv -----
// Channel   Handshake                  Payload
// input     in_valid_i / in_stall_o    scan_byte_i
// output    out_valid_o / out_stall_i  event_kind_o, key_number_o, last_event_o
//
// A byte is registered at the input, decoded against the prefix state once the
// queue has room, and its results are written into a four-entry result queue.
// A new byte can be accepted every cycle unless stalled; a completed pause
// sequence puts two results in the queue, so sustained output is one result per
// cycle when unstalled. Reset clears the prefix state, the input register and
// the queue. The input stalls while a byte is held and the queue has fewer than
// two free slots; the output head stays fixed while out_stall_i is high.
module ps2_set2_scancode_decoder_core import psd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] scan_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] event_kind_o,
  output logic [6:0] key_number_o,
  output logic       last_event_o
);

  // Input register: holds one accepted byte until it is decoded.
  logic       in_valid_q;
  logic [7:0] scan_q;
  logic       room;
  logic       fire;
  push_t      push;
  result_t    head;

  // The held byte is decoded once the queue can absorb two results.
  assign fire       = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      scan_q <= scan_byte_i;
    end
  end

  psd_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .scan_byte_i (scan_q),
    .push_o      (push)
  );

  psd_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign event_kind_o = head.kind;
  assign key_number_o = head.key;
  assign last_event_o = head.last;

endmodule

// ----- bench/ps2_set2_scancode_decoder_core_test.sv -----
module ps2_set2_scancode_decoder_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import psd_pkg::*;

  localparam int CLK_HALF_PERIOD = 5;
  localparam int RESET_CYCLES = 5;
  // Random sequences average a little over three bytes each.
  localparam int RANDOM_SEQUENCES = 500;
  // Bytes to accept before the receiver starts its long hold-off.
  localparam int HOLD_OFF_AFTER = 900;
  localparam int HOLD_OFF_CYCLES = 300;
  // Cycles to keep watching the output after the last expected event arrived.
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT = 500000;

  localparam int STD_KEYS = 85;
  localparam int EXT_KEYS = 17;
  localparam logic [6:0] EXT_KEY_BASE = 7'd85;

  // Standard make codes; the position in this list is the key number.
  localparam logic [0:STD_KEYS-1][7:0] STD_CODES = {
    8'h01, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0C,
    8'h0D, 8'h0E, 8'h11, 8'h12, 8'h14, 8'h15, 8'h16, 8'h1A, 8'h1B, 8'h1C,
    8'h1D, 8'h1E, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h29, 8'h2A,
    8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45,
    8'h46, 8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h52, 8'h54, 8'h55,
    8'h58, 8'h59, 8'h5A, 8'h5B, 8'h5D, 8'h66, 8'h69, 8'h6B, 8'h6C, 8'h70,
    8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7A,
    8'h7B, 8'h7C, 8'h7D, 8'h7E, 8'h83
  };

  // Codes that follow E0; key numbers start at EXT_KEY_BASE.
  localparam logic [0:EXT_KEYS-1][7:0] EXT_CODES = {
    8'h11, 8'h14, 8'h1F, 8'h27, 8'h2F, 8'h4A, 8'h5A, 8'h69, 8'h6B, 8'h6C,
    8'h70, 8'h71, 8'h72, 8'h74, 8'h75, 8'h7A, 8'h7D
  };

  // The full pause sequence. Entry k is also the byte awaited once k bytes
  // of the sequence have been seen.
  localparam logic [0:7][7:0] PAUSE_SEQUENCE = {
    CODE_PAUSE_LEAD, CODE_PAUSE_A, CODE_PAUSE_B, CODE_PAUSE_LEAD,
    CODE_BREAK, CODE_PAUSE_A, CODE_BREAK, CODE_PAUSE_B
  };

  typedef struct {
    logic [7:0] value;
    bit         hold;   // wait until every expected event has arrived
  } pending_byte_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] scan_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [1:0] event_kind_o;
  logic [6:0] key_number_o;
  logic       last_event_o;

  ps2_set2_scancode_decoder_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .scan_byte_i  (scan_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .event_kind_o (event_kind_o),
    .key_number_o (key_number_o),
    .last_event_o (last_event_o)
  );

  always #CLK_HALF_PERIOD clk_i = ~clk_i;

  // Bytes still to be sent, and the events the decoder owes us, oldest first.
  pending_byte_t pending_bytes[$];
  result_t       expected_events[$];

  int unsigned error_count = 0;
  int unsigned bytes_accepted = 0;
  int unsigned cycle_count = 0;
  bit          draining = 1'b0;
  bit          hold_next = 1'b0;

  // ---------------------------------------------------------------------------
  // Decoder prediction. The testbench keeps its own copy of the prefix and
  // sequence state and updates it once per accepted byte.
  // ---------------------------------------------------------------------------
  logic [2:0] pause_seen;       // bytes of the pause sequence seen so far
  logic       prtsc_half_seen;  // first half of print screen has arrived
  logic       prtsc_is_break;   // that first half was the break form
  logic       break_seen;       // F0 waiting for its code
  logic       extended_seen;    // E0 waiting for its code

  function automatic int std_index(input logic [7:0] code);
    for (int i = 0; i < STD_KEYS; i++) if (STD_CODES[i] == code) return i;
    return -1;
  endfunction

  function automatic int ext_index(input logic [7:0] code);
    for (int i = 0; i < EXT_KEYS; i++) if (EXT_CODES[i] == code) return i;
    return -1;
  endfunction

  function automatic void clear_sequence();
    pause_seen = 3'd0;
    prtsc_half_seen = 1'b0;
    prtsc_is_break = 1'b0;
    break_seen = 1'b0;
    extended_seen = 1'b0;
  endfunction

  function automatic void expect_event(input event_kind_e kind, input logic [6:0] key,
                                       input logic last);
    result_t ev;
    ev.kind = kind;
    ev.key = key;
    ev.last = last;
    expected_events.push_back(ev);
  endfunction

  // Any byte that breaks a sequence drops all state and asks for release-all.
  function automatic void expect_release_all();
    clear_sequence();
    expect_event(EV_CLEAR, KEY_NONE, 1'b1);
  endfunction

  function automatic void predict_byte(input logic [7:0] code);
    int         idx;
    logic       first_half;
    logic       was_break;
    logic [6:0] key;
    idx = -1;
    key = KEY_NONE;
    if (pause_seen != 3'd0) begin
      // Inside the pause sequence only the exact next byte is allowed.
      if (code != PAUSE_SEQUENCE[pause_seen]) begin
        expect_release_all();
      end else if (pause_seen == PAUSE_LAST_STEP) begin
        // Pause has no break code, so the press and release come together.
        clear_sequence();
        expect_event(EV_PRESS, KEY_PAUSE, 1'b0);
        expect_event(EV_RELEASE, KEY_PAUSE, 1'b1);
      end else begin
        pause_seen = pause_seen + 3'd1;
      end
    end else if (code == CODE_PAUSE_LEAD) begin
      // Pending prefixes survive until the pause sequence ends or breaks.
      pause_seen = 3'd1;
    end else if (code == CODE_EXTENDED) begin
      if (break_seen || extended_seen) expect_release_all();
      else extended_seen = 1'b1;
    end else if (code == CODE_BREAK) begin
      if (break_seen) expect_release_all();
      else break_seen = 1'b1;
    end else if (extended_seen && (code == CODE_PRTSC_A || code == CODE_PRTSC_B)) begin
      // Print screen make is E0 12 E0 7C and its break is E0 F0 7C E0 F0 12,
      // so which half a code belongs to depends on the break prefix.
      first_half = (code == CODE_PRTSC_A) ? !break_seen : break_seen;
      if (first_half == prtsc_half_seen) begin
        expect_release_all();
      end else if (first_half) begin
        prtsc_is_break = break_seen;
        prtsc_half_seen = 1'b1;
        extended_seen = 1'b0;
        break_seen = 1'b0;
      end else if (prtsc_is_break != break_seen) begin
        expect_release_all();
      end else begin
        was_break = prtsc_is_break;
        clear_sequence();
        expect_event(was_break ? EV_RELEASE : EV_PRESS, KEY_PRINT_SCREEN, 1'b1);
      end
    end else begin
      // An ordinary code. Another extended code between the print screen
      // halves is not allowed, but a plain code simply ends that sequence.
      if (extended_seen) begin
        if (!prtsc_half_seen) idx = ext_index(code);
        if (idx >= 0) key = idx[6:0] + EXT_KEY_BASE;
      end else begin
        idx = std_index(code);
        if (idx >= 0) key = idx[6:0];
      end
      if (idx < 0) begin
        expect_release_all();
      end else begin
        was_break = break_seen;
        clear_sequence();
        expect_event(was_break ? EV_RELEASE : EV_PRESS, key, 1'b1);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers used while the byte list is built.
  // ---------------------------------------------------------------------------
  function automatic void add_byte(input logic [7:0] value);
    pending_byte_t item;
    item.value = value;
    item.hold = hold_next;
    hold_next = 1'b0;
    pending_bytes.push_back(item);
  endfunction

  // One half of the print screen sequence, make or break form.
  function automatic void add_prtsc_half(input bit is_break, input bit second);
    add_byte(CODE_EXTENDED);
    if (is_break) begin
      add_byte(CODE_BREAK);
      add_byte(second ? CODE_PRTSC_A : CODE_PRTSC_B);
    end else begin
      add_byte(second ? CODE_PRTSC_B : CODE_PRTSC_A);
    end
  endfunction

  function automatic void add_pause(input int length);
    for (int i = 0; i < length; i++) add_byte(PAUSE_SEQUENCE[i]);
  endfunction

  function automatic logic [7:0] random_std_code();
    return STD_CODES[$urandom_range(0, STD_KEYS - 1)];
  endfunction

  function automatic logic [7:0] random_ext_code();
    return EXT_CODES[$urandom_range(0, EXT_KEYS - 1)];
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver. Handshakes are sampled at the rising edge, where an accepted
  // byte is also fed to the predictor; new bytes are presented at the falling
  // edge. The sender works in bursts separated by random gaps, and a byte
  // marked hold is not offered until every expected event has come back.
  // ---------------------------------------------------------------------------
  bit byte_taken = 1'b0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin : byte_accept
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_byte(scan_byte_i);
      void'(pending_bytes.pop_front());
      bytes_accepted++;
      byte_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin : byte_driver
    // A byte that is offered but not yet taken stays on the port unchanged.
    if (!in_valid_i || byte_taken) begin
      byte_taken = 1'b0;
      if (rst_ni && gap_left == 0 && pending_bytes.size() != 0 &&
          (!pending_bytes[0].hold || expected_events.size() == 0)) begin
        in_valid_i <= 1'b1;
        scan_byte_i <= pending_bytes[0].value;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // Now and then a long burst, so some stretches carry no gaps at all.
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid_i <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output stall pattern. The receiver switches between several stall modes
  // of random duration. Once, after enough bytes went in, it holds off for a
  // long stretch so that the result queue fills and the input has to stall.
  // While the end of the run is watched for stray results it never stalls.
  // ---------------------------------------------------------------------------
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(negedge clk_i) begin : stall_driver
    logic stall_next;
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      stall_next = 1'b1;
    end else if (!hold_done && bytes_accepted >= HOLD_OFF_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_OFF_CYCLES - 1;
      stall_next = 1'b1;
    end else if (draining) begin
      stall_next = 1'b0;
    end else begin
      case (stall_mode)
        0:       stall_next = 1'b0;
        1:       stall_next = ($urandom_range(0, 1) == 0);
        2:       stall_next = (mode_left % 3 == 0);
        default: stall_next = ($urandom_range(0, 4) != 0);
      endcase
    end
    out_stall_i <= stall_next;
  end

  // ---------------------------------------------------------------------------
  // Result monitor. Every transaction taken from the output is compared field
  // by field with the oldest expected event.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : event_monitor
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_events.size() == 0) begin
        $error("unexpected event: event_kind %0d key_number %0d last_event %0d",
               event_kind_o, key_number_o, last_event_o);
        error_count++;
      end else begin
        want = expected_events.pop_front();
        if (event_kind_o !== want.kind) begin
          $error("event_kind: expected %0d, got %0d", want.kind, event_kind_o);
          error_count++;
        end
        if (key_number_o !== want.key) begin
          $error("key_number: expected %0d, got %0d", want.key, key_number_o);
          error_count++;
        end
        if (last_event_o !== want.last) begin
          $error("last_event: expected %0d, got %0d", want.last, last_event_o);
          error_count++;
        end
      end
    end
  end

  // The run must end well within this many cycles, even at the slowest pace.
  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run. The whole byte list is built before reset is
  // released; the driver then drains it at its own pace.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned pick;
    int unsigned count;
    bit          is_break;

    clear_sequence();

    // Directed part: table edges, the byte extremes, extended make and break,
    // print screen, a full pause and repeated prefixes.
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(STD_CODES[0]);
    add_byte(CODE_BREAK);
    add_byte(STD_CODES[STD_KEYS - 1]);
    add_byte(CODE_EXTENDED);
    add_byte(EXT_CODES[EXT_KEYS - 1]);
    add_byte(CODE_EXTENDED);
    add_byte(CODE_BREAK);
    add_byte(EXT_CODES[0]);
    add_prtsc_half(1'b0, 1'b0);
    add_prtsc_half(1'b0, 1'b1);
    add_pause(8);
    add_byte(CODE_EXTENDED);
    add_byte(CODE_EXTENDED);
    add_byte(CODE_BREAK);
    add_byte(CODE_BREAK);

    // Random part: mostly well-formed sequences with random keys, mixed with
    // broken sequences and raw noise. The sender drains fully a few times.
    hold_next = 1'b1;
    for (int seq = 0; seq < RANDOM_SEQUENCES; seq++) begin
      if (seq % 150 == 149) hold_next = 1'b1;
      pick = $urandom_range(0, 99);
      is_break = 1'($urandom_range(0, 1));
      if (pick < 18) begin
        add_byte(random_std_code());
      end else if (pick < 32) begin
        add_byte(CODE_BREAK);
        add_byte(random_std_code());
      end else if (pick < 44) begin
        add_byte(CODE_EXTENDED);
        if (is_break) add_byte(CODE_BREAK);
        add_byte(random_ext_code());
      end else if (pick < 56) begin
        add_prtsc_half(is_break, 1'b0);
        add_prtsc_half(is_break, 1'b1);
      end else if (pick < 63) begin
        // Sometimes the pause lead arrives with a prefix still pending.
        count = $urandom_range(0, 2);
        if (count == 1) add_byte(CODE_EXTENDED);
        if (count == 2) add_byte(CODE_BREAK);
        add_pause(8);
      end else if (pick < 68) begin
        // First print screen half, then a plain or extended key.
        add_prtsc_half(is_break, 1'b0);
        if ($urandom_range(0, 2) == 0) begin
          add_byte(CODE_EXTENDED);
          add_byte(random_ext_code());
        end else begin
          if ($urandom_range(0, 1) == 0) add_byte(CODE_BREAK);
          add_byte(random_std_code());
        end
      end else if (pick < 74) begin
        // Print screen halves that disagree, or come in the wrong order.
        if ($urandom_range(0, 1) == 0) begin
          add_prtsc_half(is_break, 1'b0);
          add_prtsc_half(!is_break, 1'b1);
        end else begin
          add_prtsc_half(is_break, 1'b1);
        end
      end else if (pick < 82) begin
        // Pause cut short by an arbitrary byte.
        add_pause($urandom_range(1, 7));
        add_byte(8'($urandom_range(0, 255)));
      end else if (pick < 86) begin
        add_byte($urandom_range(0, 1) ? CODE_EXTENDED : CODE_BREAK);
        add_byte($urandom_range(0, 1) ? CODE_EXTENDED : CODE_BREAK);
        add_byte(random_std_code());
      end else begin
        count = $urandom_range(1, 3);
        repeat (count) add_byte(8'($urandom_range(0, 255)));
      end
    end

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_bytes.size() != 0 || expected_events.size() != 0) @(negedge clk_i);
    draining = 1'b1;
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (expected_events.size() != 0) begin
      $error("%0d expected events never arrived", expected_events.size());
      error_count++;
    end

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/psd_pkg.sv
design/psd_decode.sv
design/psd_out_queue.sv
design/ps2_set2_scancode_decoder_core.sv
bench/ps2_set2_scancode_decoder_core_test.sv
